// File: design/dsr_pkg.sv
// Shared types and constants for the delimited segment reverser.
package dsr_pkg;

    localparam logic [7:0] END_BYTE    = 8'd0;
    localparam logic [7:0] DELIM_RESET = 8'd35;
    localparam int         CMD_DEPTH   = 4;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_PUSH,
        CMD_FLUSH,
        CMD_CLEAR
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
    } t_cmd;

endpackage

// File: design/dsr_front.sv
// Front end: delimiter register, segment tracking and command generation.
module dsr_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    input  logic         i_accept,
    input  logic [7:0]   i_in_char,
    output logic         o_cmd_push,
    output dsr_pkg::t_cmd o_cmd
);
    import dsr_pkg::*;

    logic [7:0] r_delim;
    logic       r_inside;
    logic       n_inside;
    logic       is_end;
    logic       is_delim;

    assign is_end   = (i_in_char == END_BYTE);
    assign is_delim = (i_in_char == r_delim);

    always_comb begin
        n_inside    = r_inside;
        o_cmd_push  = 1'b0;
        o_cmd.op    = CMD_PASS;
        o_cmd.data  = i_in_char;
        if (i_accept) begin
            priority if (is_end) begin
                n_inside   = 1'b0;
                o_cmd_push = 1'b1;
                o_cmd.op   = CMD_CLEAR;
            end else if (!r_inside) begin
                if (is_delim) begin
                    n_inside = 1'b1;
                end else begin
                    o_cmd_push = 1'b1;
                    o_cmd.op   = CMD_PASS;
                end
            end else if (is_delim) begin
                n_inside   = 1'b0;
                o_cmd_push = 1'b1;
                o_cmd.op   = CMD_FLUSH;
            end else begin
                o_cmd_push = 1'b1;
                o_cmd.op   = CMD_PUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim  <= DELIM_RESET;
            r_inside <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_delim <= i_cfg_wdata;
            end
            r_inside <= n_inside;
        end
    end

endmodule

// File: design/dsr_cmd_fifo.sv
// Short command queue between the front end and the stack engine.
module dsr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  dsr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output dsr_pkg::t_cmd o_cmd
);
    import dsr_pkg::*;

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    t_cmd          r_mem [CMD_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == CW'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (rd_en) begin
                r_rptr <= r_rptr + PW'(1);
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CMD_DEPTH))
        else $error("command queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("command written into full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

endmodule

// File: design/dsr_back.sv
// Stack engine: executes commands and drives the result register.
module dsr_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  dsr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_char,
    output logic          o_last
);
    import dsr_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_EMIT
    } t_state;

    t_state        r_state;
    logic [FW-1:0] r_fill;
    logic [7:0]    r_mem [STACK_DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic          slot_free;
    logic          stack_full;
    logic          mem_wr;
    logic          out_load;
    logic [FW-1:0] fill_dec;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign slot_free  = !r_out_valid || i_pop;
    assign stack_full = (r_fill == FW'(STACK_DEPTH));
    assign fill_dec   = r_fill - FW'(1);
    assign rd_addr    = fill_dec[AW-1:0];
    assign wr_addr    = r_fill[AW-1:0];

    assign o_empty    = !r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

    always_comb begin
        o_cmd_pop = 1'b0;
        if (r_state == ST_IDLE && i_cmd_valid) begin
            o_cmd_pop = (i_cmd.op != CMD_PASS) || slot_free;
        end
    end

    assign mem_wr   = o_cmd_pop && (i_cmd.op == CMD_PUSH) && !stack_full;
    assign out_load = (r_state == ST_IDLE && o_cmd_pop && i_cmd.op == CMD_PASS) ||
                      (r_state == ST_EMIT && slot_free);

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        if (r_state == ST_RD) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.op)
                            CMD_PASS: begin
                                r_out_char  <= i_cmd.data;
                                r_out_last  <= 1'b1;
                            end
                            CMD_PUSH: begin
                                if (!stack_full) begin
                                    r_fill <= r_fill + FW'(1);
                                end
                            end
                            CMD_FLUSH: begin
                                if (r_fill != '0) begin
                                    r_state <= ST_RD;
                                end
                            end
                            CMD_CLEAR: begin
                                r_fill <= '0;
                            end
                            default: r_fill <= r_fill;
                        endcase
                    end
                end
                ST_RD: begin
                    r_fill  <= fill_dec;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_out_char  <= r_rd_data;
                        r_out_last  <= (r_fill == '0);
                        r_state     <= (r_fill == '0) ? ST_IDLE : ST_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_fill != '0))
        else $error("stack read while empty");

    a_last_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && slot_free && r_fill == '0) |=> (r_out_valid && r_out_last))
        else $error("final drained byte not marked last");

endmodule

// File: design/delimited_segment_reverser.sv
// Top level of the delimited segment reverser.
// A byte is taken in every cycle while the four-entry command queue has room; a
// pass-through byte yields one result as soon as the result register is free.
// A closing delimiter drains the stack one stacked byte at a time, first reading
// the single-port stack memory and then loading the result register, which
// waits in the back end while the result register is still full; the front
// keeps accepting meanwhile until the queue fills. No clearing pass after reset.
module delimited_segment_reverser #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_last
);
    import dsr_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd_out;

    assign accept = push && !full;

    dsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_char   (i_in_char),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    dsr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    dsr_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule
